### sv/lpmq_pkg.sv
// Shared constants, types and helper functions for the binary-lifting LCA / path-max block.
// Depends on nothing; every other file refers to it by scoped names.
package lpmq_pkg;

    // Sizing of the tree and the weights
    localparam int NODE_COUNT        = 65536;
    localparam int LEVELS            = 16;
    localparam int WEIGHT_BITS       = 32;

    // Fixed field widths at the ports
    localparam int FIELD_NODE_BITS   = 16;
    localparam int FIELD_WEIGHT_BITS = 32;
    localparam int DEPTH_BITS        = 16;

    // Derived widths
    localparam int NODE_BITS  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LEVEL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_BITS   = NODE_BITS + 1;
    localparam int LIFT_DEPTH = NODE_COUNT * LEVELS;
    localparam int LIFT_ABITS = (LIFT_DEPTH > 1) ? $clog2(LIFT_DEPTH) : 1;
    localparam int GAP_BITS   = (LEVELS > DEPTH_BITS) ? LEVELS + 1 : DEPTH_BITS + 1;
    localparam int RED_BITS   = (NODE_BITS > FIELD_NODE_BITS) ? NODE_BITS + 1
                                                              : FIELD_NODE_BITS + 1;

    // Reciprocal for reducing a node field modulo the node count
    localparam logic [31:0] RECIP         = 32'((64'd1 << 32) / NODE_COUNT);
    localparam logic [15:0] NODE_COUNT_LO = 16'(NODE_COUNT);

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [NODE_BITS-1:0]   t_node;
    typedef logic [ANC_BITS-1:0]    t_anc;
    typedef logic [DEPTH_BITS-1:0]  t_depth;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [LEVEL_BITS-1:0]  t_level;
    typedef logic [LIFT_ABITS-1:0]  t_lift_addr;

    localparam t_level K_LAST = t_level'(LEVELS - 1);

    // One lifting entry: 2^k ancestor plus one (zero = none) and the jump maximum
    typedef struct packed {
        t_anc    anc;
        t_weight jm;
    } t_lift_entry;

    typedef struct packed {
        logic        en;
        t_lift_addr  addr;
        t_lift_entry data;
    } t_lift_wr;

    typedef struct packed {
        logic   en;
        t_node  addr;
        t_depth data;
    } t_depth_wr;

    // Work done by the shared compare unit for one step
    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_CLIMB,
        STEP_MEET,
        STEP_FINAL
    } t_step_mode;

    typedef struct packed {
        t_step_mode mode;
        t_weight    acc;
        t_weight    x0;
        t_weight    x1;
        t_anc       anc0;
        t_anc       anc1;
        t_depth     du;
        t_depth     dv;
        t_level     k;
    } t_step_req;

    typedef struct packed {
        logic    take;
        t_weight wmax;
    } t_step_res;

    // Address of level k of a node in the lifting tables
    function automatic t_lift_addr lift_addr(t_node n, t_level k);
        return t_lift_addr'(n) * t_lift_addr'(LEVELS) + t_lift_addr'(k);
    endfunction

    // Node held by a nonzero ancestor entry
    function automatic t_node anc_to_node(t_anc a);
        t_anc d;
        d = a - t_anc'(1);
        return d[NODE_BITS-1:0];
    endfunction

    function automatic t_anc node_to_anc(t_node n);
        return t_anc'(n) + t_anc'(1);
    endfunction

    function automatic t_weight weight_from_field(logic [FIELD_WEIGHT_BITS-1:0] x);
        logic [WEIGHT_BITS+FIELD_WEIGHT_BITS-1:0] wide;
        wide = {{WEIGHT_BITS{1'b0}}, x};
        return wide[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [FIELD_WEIGHT_BITS-1:0] weight_to_field(t_weight w);
        logic [WEIGHT_BITS+FIELD_WEIGHT_BITS-1:0] wide;
        wide = {{FIELD_WEIGHT_BITS{1'b0}}, w};
        return wide[FIELD_WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [FIELD_NODE_BITS-1:0] node_to_field(t_node n);
        logic [NODE_BITS+FIELD_NODE_BITS-1:0] wide;
        wide = {{FIELD_NODE_BITS{1'b0}}, n};
        return wide[FIELD_NODE_BITS-1:0];
    endfunction

endpackage

### sv/lpmq_tables.sv
// Lifting table (ancestor and jump maximum per node and level) and depth table.
// One write port and two registered read ports each; uses lpmq_pkg.
module lpmq_tables (
    input  logic                  i_clk,
    input  lpmq_pkg::t_lift_wr    i_lift_wr,
    input  lpmq_pkg::t_lift_addr  i_lift_raddr0,
    input  lpmq_pkg::t_lift_addr  i_lift_raddr1,
    output lpmq_pkg::t_lift_entry o_lift_rdata0,
    output lpmq_pkg::t_lift_entry o_lift_rdata1,
    input  lpmq_pkg::t_depth_wr   i_depth_wr,
    input  lpmq_pkg::t_node       i_depth_raddr0,
    input  lpmq_pkg::t_node       i_depth_raddr1,
    output lpmq_pkg::t_depth      o_depth_rdata0,
    output lpmq_pkg::t_depth      o_depth_rdata1
);

    lpmq_pkg::t_lift_entry r_lift_mem [lpmq_pkg::LIFT_DEPTH];
    lpmq_pkg::t_depth      r_depth_mem [lpmq_pkg::NODE_COUNT];

    lpmq_pkg::t_lift_entry r_lift_rd0;
    lpmq_pkg::t_lift_entry r_lift_rd1;
    lpmq_pkg::t_depth      r_depth_rd0;
    lpmq_pkg::t_depth      r_depth_rd1;

    // Write and read the lifting table
    always_ff @(posedge i_clk) begin
        if (i_lift_wr.en) begin
            r_lift_mem[i_lift_wr.addr] <= i_lift_wr.data;
        end
        r_lift_rd0 <= r_lift_mem[i_lift_raddr0];
        r_lift_rd1 <= r_lift_mem[i_lift_raddr1];
    end

    // Write and read the depth table
    always_ff @(posedge i_clk) begin
        if (i_depth_wr.en) begin
            r_depth_mem[i_depth_wr.addr] <= i_depth_wr.data;
        end
        r_depth_rd0 <= r_depth_mem[i_depth_raddr0];
        r_depth_rd1 <= r_depth_mem[i_depth_raddr1];
    end

    assign o_lift_rdata0  = r_lift_rd0;
    assign o_lift_rdata1  = r_lift_rd1;
    assign o_depth_rdata0 = r_depth_rd0;
    assign o_depth_rdata1 = r_depth_rd1;

endmodule

### sv/lpmq_step_unit.sv
// Shared compare unit: running weight maximum and the jump decision of one level.
// Combinational; uses lpmq_pkg.
module lpmq_step_unit (
    input  lpmq_pkg::t_step_req i_req,
    output lpmq_pkg::t_step_res o_res
);

    lpmq_pkg::t_weight             w_m01;
    logic [lpmq_pkg::GAP_BITS-1:0] w_gap;
    logic [lpmq_pkg::GAP_BITS-1:0] w_span;

    // Depth gap against the jump length of this level
    assign w_gap  = lpmq_pkg::GAP_BITS'(lpmq_pkg::t_depth'(i_req.du - i_req.dv));
    assign w_span = lpmq_pkg::GAP_BITS'(1) << i_req.k;

    // Merge the candidate weights into the running maximum and decide the jump
    always_comb begin
        w_m01      = (i_req.x0 > i_req.x1) ? i_req.x0 : i_req.x1;
        o_res.wmax = (i_req.acc > w_m01) ? i_req.acc : w_m01;
        case (i_req.mode)
            lpmq_pkg::STEP_LOAD: begin
                o_res.take = 1'b1;
            end
            lpmq_pkg::STEP_CLIMB: begin
                o_res.take = (i_req.du >= i_req.dv) && (w_gap >= w_span)
                             && (i_req.anc0 != '0);
            end
            lpmq_pkg::STEP_MEET: begin
                o_res.take = (i_req.anc0 != i_req.anc1) && (i_req.anc0 != '0)
                             && (i_req.anc1 != '0);
            end
            lpmq_pkg::STEP_FINAL: begin
                o_res.take = (i_req.anc0 != '0);
            end
            default: begin
                o_res.take = 1'b0;
            end
        endcase
    end

endmodule

### sv/lca_path_max_query.sv
// Top level: sequencer for loads and path queries over the lifting tables.
// Uses lpmq_pkg, lpmq_tables and lpmq_step_unit.
//
// Input channel i_valid / o_ready carries one item: a load (opcode 0) enters a
// node with its parent and edge weight, or marks it as a root; a query
// (opcode 1) names two nodes. Parents must be loaded before their children; the
// block does not enforce this. Output channel o_valid / i_ready carries one
// result per query: the lowest common ancestor and the largest edge weight on
// the path. Loads give none. The block handles one item at a time; o_ready is
// high only when idle. Node indexes are first reduced modulo the node count.
// The work then follows the chain of dependent lifting-table reads, one level
// at a time (read, then compare in the shared unit): a root load clears the L
// levels (16 here), a child load builds them in turn, and a query climbs them
// once when the nodes meet on the climb, else twice. Results are registered.
// A finished result sits in the output register; if the receiver stalls, the
// next query result waits in the sequencer until that register frees up.
// Reset (synchronous, active low) returns to idle and drops o_valid; table
// contents are not cleared, and an entry reads as undefined until loaded.
module lca_path_max_query (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_node_a,
    input  logic [15:0] i_node_b,
    input  logic        i_has_parent,
    input  logic [31:0] i_edge_weight,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_common_ancestor,
    output logic [31:0] o_path_max
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_QA,
        S_RED_RA,
        S_RED_QB,
        S_RED_RB,
        S_LD_ROOT,
        S_LD_DEP,
        S_LD_BASE,
        S_LD_RD,
        S_LD_WR,
        S_Q_DEP,
        S_Q_SWAP,
        S_P1_RD,
        S_P1_EV,
        S_CHK,
        S_P2_RD,
        S_P2_EV,
        S_FIN_RD,
        S_FIN_EV,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [15:0]         r_a, n_a;
    logic [15:0]         r_b, n_b;
    logic                r_has_p, n_has_p;
    lpmq_pkg::t_weight   r_w, n_w;
    logic [15:0]         r_q, n_q;
    lpmq_pkg::t_node     r_u, n_u;
    lpmq_pkg::t_node     r_v, n_v;
    lpmq_pkg::t_depth    r_dv, n_dv;
    lpmq_pkg::t_level    r_k, n_k;
    lpmq_pkg::t_anc      r_up, n_up;
    lpmq_pkg::t_weight   r_jm, n_jm;
    lpmq_pkg::t_weight   r_best, n_best;
    lpmq_pkg::t_node     r_res_anc, n_res_anc;
    logic                r_out_valid, n_out_valid;
    logic [15:0]         r_out_anc, n_out_anc;
    logic [31:0]         r_out_max, n_out_max;

    lpmq_pkg::t_lift_wr    w_lift_wr;
    lpmq_pkg::t_lift_addr  w_lift_raddr0;
    lpmq_pkg::t_lift_addr  w_lift_raddr1;
    lpmq_pkg::t_lift_entry w_lift_rd0;
    lpmq_pkg::t_lift_entry w_lift_rd1;
    lpmq_pkg::t_depth_wr   w_depth_wr;
    lpmq_pkg::t_node       w_depth_raddr0;
    lpmq_pkg::t_node       w_depth_raddr1;
    lpmq_pkg::t_depth      w_depth_rd0;
    lpmq_pkg::t_depth      w_depth_rd1;
    lpmq_pkg::t_step_req   w_step_req;
    lpmq_pkg::t_step_res   w_step_res;

    logic [15:0]                   w_red_x;
    logic [47:0]                   w_red_prod;
    logic [15:0]                   w_red_diff;
    logic [lpmq_pkg::RED_BITS-1:0] w_red_wide;
    logic [lpmq_pkg::RED_BITS-1:0] w_red_rem;
    lpmq_pkg::t_node               w_red_node;

    lpmq_tables u_tables (
        .i_clk          (i_clk),
        .i_lift_wr      (w_lift_wr),
        .i_lift_raddr0  (w_lift_raddr0),
        .i_lift_raddr1  (w_lift_raddr1),
        .o_lift_rdata0  (w_lift_rd0),
        .o_lift_rdata1  (w_lift_rd1),
        .i_depth_wr     (w_depth_wr),
        .i_depth_raddr0 (w_depth_raddr0),
        .i_depth_raddr1 (w_depth_raddr1),
        .o_depth_rdata0 (w_depth_rd0),
        .o_depth_rdata1 (w_depth_rd1)
    );

    lpmq_step_unit u_step (
        .i_req (w_step_req),
        .o_res (w_step_res)
    );

    // Reduce a node field modulo the node count: quotient estimate, then fix up
    always_comb begin
        w_red_x    = (r_state == S_RED_QA || r_state == S_RED_RA) ? r_a : r_b;
        w_red_prod = 48'(w_red_x) * 48'(lpmq_pkg::RECIP);
        w_red_diff = w_red_x - 16'(r_q * lpmq_pkg::NODE_COUNT_LO);
        w_red_wide = lpmq_pkg::RED_BITS'(w_red_diff);
        w_red_rem  = (w_red_wide >= lpmq_pkg::RED_BITS'(lpmq_pkg::NODE_COUNT))
                     ? w_red_wide - lpmq_pkg::RED_BITS'(lpmq_pkg::NODE_COUNT)
                     : w_red_wide;
        w_red_node = w_red_rem[lpmq_pkg::NODE_BITS-1:0];
    end

    // Feed the shared compare unit
    always_comb begin
        w_step_req.mode = lpmq_pkg::STEP_LOAD;
        w_step_req.acc  = r_best;
        w_step_req.x0   = w_lift_rd0.jm;
        w_step_req.x1   = w_lift_rd1.jm;
        w_step_req.anc0 = w_lift_rd0.anc;
        w_step_req.anc1 = w_lift_rd1.anc;
        w_step_req.du   = w_depth_rd0;
        w_step_req.dv   = r_dv;
        w_step_req.k    = r_k;
        case (r_state)
            S_LD_WR: begin
                w_step_req.mode = lpmq_pkg::STEP_LOAD;
                w_step_req.acc  = r_jm;
                w_step_req.x1   = w_lift_rd0.jm;
            end
            S_P1_EV: begin
                w_step_req.mode = lpmq_pkg::STEP_CLIMB;
                w_step_req.x1   = w_lift_rd0.jm;
            end
            S_P2_EV: begin
                w_step_req.mode = lpmq_pkg::STEP_MEET;
            end
            S_FIN_EV: begin
                w_step_req.mode = lpmq_pkg::STEP_FINAL;
            end
            default: begin
                w_step_req.mode = lpmq_pkg::STEP_LOAD;
            end
        endcase
    end

    // Sequencer next state, table ports and result hand-off
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_has_p     = r_has_p;
        n_w         = r_w;
        n_q         = r_q;
        n_u         = r_u;
        n_v         = r_v;
        n_dv        = r_dv;
        n_k         = r_k;
        n_up        = r_up;
        n_jm        = r_jm;
        n_best      = r_best;
        n_res_anc   = r_res_anc;
        n_out_valid = r_out_valid;
        n_out_anc   = r_out_anc;
        n_out_max   = r_out_max;

        w_lift_wr      = '0;
        w_depth_wr     = '0;
        w_lift_raddr0  = lpmq_pkg::lift_addr(r_u, r_k);
        w_lift_raddr1  = lpmq_pkg::lift_addr(r_v, r_k);
        w_depth_raddr0 = r_u;
        w_depth_raddr1 = r_v;

        // Drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_has_p = i_has_parent;
                    n_w     = lpmq_pkg::weight_from_field(i_edge_weight);
                    n_state = S_RED_QA;
                end
            end
            S_RED_QA: begin
                n_q     = w_red_prod[47:32];
                n_state = S_RED_RA;
            end
            S_RED_RA: begin
                n_u     = w_red_node;
                n_state = S_RED_QB;
            end
            S_RED_QB: begin
                n_q     = w_red_prod[47:32];
                n_state = S_RED_RB;
            end
            S_RED_RB: begin
                n_v    = w_red_node;
                n_k    = '0;
                n_best = '0;
                if (r_op == lpmq_pkg::OP_QUERY) begin
                    n_state = S_Q_DEP;
                end else if (r_has_p) begin
                    n_state = S_LD_DEP;
                end else begin
                    n_state = S_LD_ROOT;
                end
            end
            // Root: clear every level, depth zero
            S_LD_ROOT: begin
                w_lift_wr.en    = 1'b1;
                w_lift_wr.addr  = lpmq_pkg::lift_addr(r_u, r_k);
                w_depth_wr.en   = 1'b1;
                w_depth_wr.addr = r_u;
                if (r_k == lpmq_pkg::K_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + lpmq_pkg::t_level'(1);
                end
            end
            S_LD_DEP: begin
                w_depth_raddr0 = r_v;
                n_state        = S_LD_BASE;
            end
            // Child: depth from parent, level zero is the parent itself
            S_LD_BASE: begin
                w_depth_wr.en      = 1'b1;
                w_depth_wr.addr    = r_u;
                w_depth_wr.data    = w_depth_rd0 + lpmq_pkg::t_depth'(1);
                w_lift_wr.en       = 1'b1;
                w_lift_wr.addr     = lpmq_pkg::lift_addr(r_u, '0);
                w_lift_wr.data.anc = lpmq_pkg::node_to_anc(r_v);
                w_lift_wr.data.jm  = r_w;
                n_up               = lpmq_pkg::node_to_anc(r_v);
                n_jm               = r_w;
                if (lpmq_pkg::LEVELS == 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = lpmq_pkg::t_level'(1);
                    n_state = S_LD_RD;
                end
            end
            // Look up the ancestor's entry one level down, or write an empty level
            S_LD_RD: begin
                w_lift_raddr0 = lpmq_pkg::lift_addr(lpmq_pkg::anc_to_node(r_up),
                                                    r_k - lpmq_pkg::t_level'(1));
                if (r_up == '0) begin
                    w_lift_wr.en   = 1'b1;
                    w_lift_wr.addr = lpmq_pkg::lift_addr(r_u, r_k);
                    n_jm           = '0;
                    if (r_k == lpmq_pkg::K_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + lpmq_pkg::t_level'(1);
                    end
                end else begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                w_lift_wr.en       = 1'b1;
                w_lift_wr.addr     = lpmq_pkg::lift_addr(r_u, r_k);
                w_lift_wr.data.anc = w_lift_rd0.anc;
                w_lift_wr.data.jm  = w_step_res.wmax;
                n_up               = w_lift_rd0.anc;
                n_jm               = w_step_res.wmax;
                if (r_k == lpmq_pkg::K_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + lpmq_pkg::t_level'(1);
                    n_state = S_LD_RD;
                end
            end
            S_Q_DEP: begin
                n_state = S_Q_SWAP;
            end
            // Put the deeper node in u
            S_Q_SWAP: begin
                if (w_depth_rd0 < w_depth_rd1) begin
                    n_u  = r_v;
                    n_v  = r_u;
                    n_dv = w_depth_rd0;
                end else begin
                    n_dv = w_depth_rd1;
                end
                n_k     = lpmq_pkg::K_LAST;
                n_state = S_P1_RD;
            end
            S_P1_RD: begin
                n_state = S_P1_EV;
            end
            // Climb u toward the depth of v
            S_P1_EV: begin
                if (w_step_res.take) begin
                    n_best = w_step_res.wmax;
                    n_u    = lpmq_pkg::anc_to_node(w_lift_rd0.anc);
                end
                if (r_k == '0) begin
                    n_state = S_CHK;
                end else begin
                    n_k     = r_k - lpmq_pkg::t_level'(1);
                    n_state = S_P1_RD;
                end
            end
            S_CHK: begin
                if (r_u == r_v) begin
                    n_res_anc = r_u;
                    n_state   = S_DONE;
                end else begin
                    n_k     = lpmq_pkg::K_LAST;
                    n_state = S_P2_RD;
                end
            end
            S_P2_RD: begin
                n_state = S_P2_EV;
            end
            // Lift both nodes while their ancestors differ
            S_P2_EV: begin
                if (w_step_res.take) begin
                    n_best = w_step_res.wmax;
                    n_u    = lpmq_pkg::anc_to_node(w_lift_rd0.anc);
                    n_v    = lpmq_pkg::anc_to_node(w_lift_rd1.anc);
                end
                if (r_k == '0) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_k     = r_k - lpmq_pkg::t_level'(1);
                    n_state = S_P2_RD;
                end
            end
            S_FIN_RD: begin
                n_state = S_FIN_EV;
            end
            // Last edges into the common parent
            S_FIN_EV: begin
                n_best    = w_step_res.wmax;
                n_res_anc = w_step_res.take ? lpmq_pkg::anc_to_node(w_lift_rd0.anc) : '0;
                n_state   = S_DONE;
            end
            // Hold the result until the output register is free
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = lpmq_pkg::node_to_field(r_res_anc);
                    n_out_max   = lpmq_pkg::weight_to_field(r_best);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_a       <= n_a;
        r_b       <= n_b;
        r_has_p   <= n_has_p;
        r_w       <= n_w;
        r_q       <= n_q;
        r_u       <= n_u;
        r_v       <= n_v;
        r_dv      <= n_dv;
        r_k       <= n_k;
        r_up      <= n_up;
        r_jm      <= n_jm;
        r_best    <= n_best;
        r_res_anc <= n_res_anc;
        r_out_anc <= n_out_anc;
        r_out_max <= n_out_max;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_common_ancestor = r_out_anc;
    assign o_path_max        = r_out_max;

endmodule

### sv/lpmq_checker.sv
// Port-level checks for lca_path_max_query, attached by the bind at the end.
// Uses lpmq_pkg for the opcode names.
module lpmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_opcode,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_common_ancestor,
    input logic [31:0] o_path_max
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_common_ancestor) && $stable(o_path_max))
        else $error("result changed while stalled");

    // Busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an item was taken");

    // A query keeps the block busy after it is taken
    a_query_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == lpmq_pkg::OP_QUERY
        |=> !o_ready ##1 !o_ready ##1 !o_ready)
        else $error("query finished too early");

    // A new result appears only out of a busy block
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

    // Reset drops the result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind lca_path_max_query lpmq_checker u_lpmq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_opcode          (i_opcode),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_common_ancestor (o_common_ancestor),
    .o_path_max        (o_path_max)
);

### tb/tb.sv
// Self-checking bench for lca_path_max_query: loads rooted weighted trees,
// asks path queries and checks each answer against a binary-lifting predictor.
// Depends on lpmq_pkg for widths and opcodes and on the lca_path_max_query RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit [15:0] anc;
        bit [31:0] pmax;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [15:0] i_node_a;
    logic [15:0] i_node_b;
    logic        i_has_parent;
    logic [31:0] i_edge_weight;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_common_ancestor;
    logic [31:0] o_path_max;

    // Predictor copy of the lifting tables, indexed node * LEVELS + level
    bit [lpmq_pkg::ANC_BITS-1:0]    up_tab   [lpmq_pkg::LIFT_DEPTH];
    bit [lpmq_pkg::WEIGHT_BITS-1:0] jmax_tab [lpmq_pkg::LIFT_DEPTH];
    bit [lpmq_pkg::DEPTH_BITS-1:0]  depth_of [lpmq_pkg::NODE_COUNT];

    bit          node_loaded [lpmq_pkg::NODE_COUNT];
    int unsigned loaded_nodes[$];
    t_answer     answer_q[$];
    int          mismatch_count;
    bit          steady_flow;

    lca_path_max_query dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_has_parent     (i_has_parent),
        .i_edge_weight    (i_edge_weight),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_common_ancestor(o_common_ancestor),
        .o_path_max       (o_path_max)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random unless a steady stretch is running
    always @(negedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= 36);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic bit [lpmq_pkg::WEIGHT_BITS-1:0] wider(
        input bit [lpmq_pkg::WEIGHT_BITS-1:0] x,
        input bit [lpmq_pkg::WEIGHT_BITS-1:0] y);
        return (x > y) ? x : y;
    endfunction

    // Enter one node: depth, every ancestor level and every jump maximum
    function automatic void tree_load(input int unsigned a, input int unsigned p,
                                      input bit hp, input bit [31:0] w);
        int unsigned up;
        int unsigned q;
        int          k;
        if (!hp) begin
            depth_of[a] = '0;
            for (k = 0; k < lpmq_pkg::LEVELS; k++) begin
                up_tab[a * lpmq_pkg::LEVELS + k]   = '0;
                jmax_tab[a * lpmq_pkg::LEVELS + k] = '0;
            end
            return;
        end
        depth_of[a] = depth_of[p] + 1'b1;
        up_tab[a * lpmq_pkg::LEVELS]   = lpmq_pkg::ANC_BITS'(p + 1);
        jmax_tab[a * lpmq_pkg::LEVELS] = w[lpmq_pkg::WEIGHT_BITS-1:0];
        for (k = 1; k < lpmq_pkg::LEVELS; k++) begin
            up = up_tab[a * lpmq_pkg::LEVELS + k - 1];
            if (up == 0) begin
                up_tab[a * lpmq_pkg::LEVELS + k]   = '0;
                jmax_tab[a * lpmq_pkg::LEVELS + k] = '0;
            end else begin
                q = up - 1;
                up_tab[a * lpmq_pkg::LEVELS + k]   = up_tab[q * lpmq_pkg::LEVELS + k - 1];
                jmax_tab[a * lpmq_pkg::LEVELS + k] =
                    wider(jmax_tab[a * lpmq_pkg::LEVELS + k - 1],
                          jmax_tab[q * lpmq_pkg::LEVELS + k - 1]);
            end
        end
    endfunction

    // Climb both nodes to their meeting point, gathering the largest edge
    function automatic t_answer path_query(input int unsigned u_in, input int unsigned v_in);
        int unsigned                    u;
        int unsigned                    v;
        int unsigned                    du;
        int unsigned                    dv;
        int unsigned                    up;
        int unsigned                    au;
        int unsigned                    av;
        int unsigned                    top;
        int                             k;
        bit [lpmq_pkg::WEIGHT_BITS-1:0] best;
        t_answer                        r;
        u = u_in;
        v = v_in;
        best = '0;
        if (depth_of[u] < depth_of[v]) begin
            u = v_in;
            v = u_in;
        end
        // Lift the deeper node to the depth of the other
        for (k = lpmq_pkg::LEVELS - 1; k >= 0; k--) begin
            du = depth_of[u];
            dv = depth_of[v];
            up = up_tab[u * lpmq_pkg::LEVELS + k];
            if (du >= dv && du - dv >= (1 << k) && up != 0) begin
                best = wider(best, jmax_tab[u * lpmq_pkg::LEVELS + k]);
                u = up - 1;
            end
        end
        if (u == v) begin
            r.anc  = u[15:0];
            r.pmax = best;
            return r;
        end
        // Lift both while their ancestors differ
        for (k = lpmq_pkg::LEVELS - 1; k >= 0; k--) begin
            au = up_tab[u * lpmq_pkg::LEVELS + k];
            av = up_tab[v * lpmq_pkg::LEVELS + k];
            if (au != av && au != 0 && av != 0) begin
                best = wider(best, wider(jmax_tab[u * lpmq_pkg::LEVELS + k],
                                         jmax_tab[v * lpmq_pkg::LEVELS + k]));
                u = au - 1;
                v = av - 1;
            end
        end
        best = wider(best, wider(jmax_tab[u * lpmq_pkg::LEVELS],
                                 jmax_tab[v * lpmq_pkg::LEVELS]));
        top = up_tab[u * lpmq_pkg::LEVELS];
        r.anc  = (top == 0) ? 16'd0 : 16'(top - 1);
        r.pmax = best;
        return r;
    endfunction

    // Send one item, idling first at random; predict once it is accepted
    task automatic send_item(input logic op, input int unsigned a, input int unsigned b,
                             input logic hp, input logic [31:0] w);
        int unsigned na;
        int unsigned nb;
        @(negedge i_clk);
        if (!steady_flow) begin
            while ($urandom_range(99) < 36) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_opcode      = op;
        i_node_a      = a[15:0];
        i_node_b      = b[15:0];
        i_has_parent  = hp;
        i_edge_weight = w;
        i_valid       = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        na = a[15:0] % lpmq_pkg::NODE_COUNT;
        nb = b[15:0] % lpmq_pkg::NODE_COUNT;
        if (op == lpmq_pkg::OP_LOAD) begin
            tree_load(na, nb, hp, w);
            if (!node_loaded[na]) begin
                node_loaded[na] = 1'b1;
                loaded_nodes = {loaded_nodes, na};
            end
        end else begin
            answer_q = {answer_q, path_query(na, nb)};
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Compare each accepted result with the oldest expected answer
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result anc %0d max %0h",
                                          o_common_ancestor, o_path_max));
            end else begin
                want = answer_q.pop_front();
                if (o_common_ancestor !== want.anc) begin
                    report_mismatch($sformatf("common_ancestor %0d, want %0d",
                                              o_common_ancestor, want.anc));
                end
                if (o_path_max !== want.pmax) begin
                    report_mismatch($sformatf("path_max %0h, want %0h",
                                              o_path_max, want.pmax));
                end
            end
        end
    end

    function automatic int unsigned fresh_node();
        int unsigned n;
        n = $urandom_range(65535);
        while (node_loaded[n]) n = $urandom_range(65535);
        return n;
    endfunction

    function automatic int unsigned any_loaded();
        return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
    endfunction

    // Favor recent nodes so that chains grow deep
    function automatic int unsigned recent_loaded();
        int span;
        span = (loaded_nodes.size() > 20) ? 19 : loaded_nodes.size() - 1;
        return loaded_nodes[loaded_nodes.size() - 1 - $urandom_range(span)];
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_query(input int unsigned a, input int unsigned b);
        send_item(lpmq_pkg::OP_QUERY, a, b, 1'($urandom_range(1)), $urandom);
    endtask

    // One random item: mostly queries and child loads, some roots and reloads
    task automatic send_random_item();
        int unsigned pick;
        int unsigned a;
        pick = $urandom_range(99);
        if (pick < 55) begin
            a = any_loaded();
            send_query(a, ($urandom_range(9) == 0) ? a : any_loaded());
        end else if (pick < 88) begin
            send_item(lpmq_pkg::OP_LOAD, fresh_node(),
                      ($urandom_range(1) == 0) ? recent_loaded() : any_loaded(),
                      1'b1, pick_weight());
        end else if (pick < 93) begin
            send_item(lpmq_pkg::OP_LOAD, fresh_node(), $urandom_range(65535), 1'b0,
                      $urandom);
        end else begin
            // Re-parent a node that is already in a tree, itself allowed
            send_item(lpmq_pkg::OP_LOAD, any_loaded(), any_loaded(), 1'b1, pick_weight());
        end
    endtask

    task automatic test_directed();
        send_item(lpmq_pkg::OP_LOAD, 0, 65535, 1'b0, 32'hFFFF_FFFF);
        send_item(lpmq_pkg::OP_LOAD, 65535, 0, 1'b1, 32'hFFFF_FFFF);
        send_item(lpmq_pkg::OP_LOAD, 1, 0, 1'b1, 32'h0000_0000);
        send_item(lpmq_pkg::OP_LOAD, 2, 1, 1'b1, 32'd5);
        send_item(lpmq_pkg::OP_LOAD, 3, 2, 1'b1, 32'h8000_0000);
        send_item(lpmq_pkg::OP_LOAD, 4, 3, 1'b1, 32'd7);
        send_item(lpmq_pkg::OP_LOAD, 100, 0, 1'b0, 32'h1234_5678);
        send_item(lpmq_pkg::OP_LOAD, 101, 100, 1'b1, 32'd9);
        // Equal nodes, ancestor pairs both ways, general pair
        send_query(0, 0);
        send_query(4, 4);
        send_query(4, 0);
        send_query(0, 4);
        send_query(65535, 4);
        send_query(4, 65535);
        send_query(2, 3);
        // Nodes in different trees
        send_query(101, 4);
        send_query(100, 0);
        // Re-parent a loaded node
        send_item(lpmq_pkg::OP_LOAD, 4, 1, 1'b1, 32'd3);
        send_query(4, 3);
        // A node that names itself as parent
        send_item(lpmq_pkg::OP_LOAD, 200, 0, 1'b0, 32'd0);
        send_item(lpmq_pkg::OP_LOAD, 200, 200, 1'b1, 32'd11);
        send_query(200, 200);
        send_query(200, 0);
    endtask

    task automatic test_deep_chain();
        int unsigned chain[$];
        int unsigned n;
        int          i;
        steady_flow = 1'b1;
        n = fresh_node();
        send_item(lpmq_pkg::OP_LOAD, n, $urandom_range(65535), 1'b0, $urandom);
        chain = {chain, n};
        for (i = 0; i < 280; i++) begin
            n = fresh_node();
            send_item(lpmq_pkg::OP_LOAD, n,
                      ($urandom_range(9) == 0) ? chain[$urandom_range(chain.size() - 1)]
                                               : chain[chain.size() - 1],
                      1'b1, pick_weight());
            chain = {chain, n};
        end
        for (i = 0; i < 40; i++) begin
            send_query(chain[$urandom_range(chain.size() - 1)],
                       ($urandom_range(3) == 0) ? any_loaded()
                                                : chain[$urandom_range(chain.size() - 1)]);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_forest();
        int i;
        for (i = 0; i < 3; i++) begin
            send_item(lpmq_pkg::OP_LOAD, fresh_node(), $urandom_range(65535), 1'b0,
                      $urandom);
        end
        for (i = 0; i < 850; i++) begin
            send_random_item();
        end
    endtask

    // Hold the sender until every answer is back, then resume
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 8; i++) begin
            send_query(any_loaded(), any_loaded());
        end
        drop_valid();
        while (answer_q.size() != 0) @(posedge i_clk);
        for (i = 0; i < 90; i++) begin
            send_random_item();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = lpmq_pkg::OP_LOAD;
        i_node_a      = '0;
        i_node_b      = '0;
        i_has_parent  = 1'b0;
        i_edge_weight = '0;
        i_ready       = 1'b0;
        steady_flow   = 1'b0;
        mismatch_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_deep_chain();
        test_random_forest();
        test_drain_pause();

        // Drain the answers, then watch for stray results
        drop_valid();
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
